// ----- rtl/core/matrix_ring_rotator_top_defines.svh -----
// Assertion macros shared by the matrix ring rotator RTL.
`ifndef MATRIX_RING_ROTATOR_TOP_DEFINES_SVH
`define MATRIX_RING_ROTATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define MRR_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("matrix ring rotator check failed");
// Condition that must never be seen outside reset.
`define MRR_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("matrix ring rotator forbidden condition seen");
`else
`define MRR_ASSERT(label, clk, rst_n, prop)
`define MRR_NEVER(label, clk, rst_n, cond)
`endif

`endif

// ----- rtl/core/mrr_pkg.sv -----
// Shared types and constants of the matrix ring rotator.
`timescale 1ns / 1ps
`default_nettype none
package mrr_pkg;

	localparam int DATA_W = 32;
	localparam int IDX_W  = 8;
	localparam int DIM_W  = 9;
	localparam int PER_W  = DIM_W + 2;
	localparam int CNT_W  = $clog2(DATA_W);

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	localparam logic [1:0] REG_ROW_COUNT      = 2'd0;
	localparam logic [1:0] REG_COL_COUNT      = 2'd1;
	localparam logic [1:0] REG_ROTATION_STEPS = 2'd2;

	localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(2);
	localparam logic [DIM_W-1:0] DIM_MIN   = DIM_W'(2);

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] dividend;
		logic [PER_W-1:0]  divisor;
	} rem_req_t;

	typedef struct packed {
		logic             done;
		logic [PER_W-1:0] remainder;
	} rem_rsp_t;

endpackage
`default_nettype wire

// ----- rtl/core/mrr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mrr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/mrr_rem_unit.sv -----
// Bit-serial restoring remainder unit: one dividend bit per clock cycle.
`timescale 1ns / 1ps
`default_nettype none
module mrr_rem_unit
	import mrr_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire rem_req_t req,
	output rem_rsp_t      rsp
);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] dvd_q;
	logic [PER_W-1:0]  div_q;
	logic [PER_W-1:0]  rem_q;
	logic [PER_W:0]    trial;
	logic [PER_W-1:0]  rem_next;

	// The partial remainder stays below the divisor, so one subtract restores it.
	always_comb begin
		trial = {rem_q, dvd_q[DATA_W-1]};
		if (trial >= {1'b0, div_q}) begin
			rem_next = PER_W'(trial - {1'b0, div_q});
		end else begin
			rem_next = trial[PER_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			dvd_q <= req.dividend;
			div_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DATA_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign rsp.done      = done_q;
	assign rsp.remainder = rem_q;

endmodule
`default_nettype wire

// ----- rtl/core/matrix_ring_rotator_top.sv -----
// Top level of the matrix ring rotator: configuration, sequencer, matrix store.
`timescale 1ns / 1ps
`default_nettype none
`include "matrix_ring_rotator_top_defines.svh"

// The block holds a matrix of signed 32-bit elements in a MAX_DIM x MAX_DIM
// store and answers read requests with the element that lands on the given
// position once every concentric ring is rotated counterclockwise by
// rotation_steps. A request is taken at a rising edge with start high and busy
// low. A write request is stored at that edge and busy never rises, so writes
// can follow one per cycle. A read request holds busy high through the ring
// geometry states GEOM, SIZE and POS, the bit-serial remainder unit that
// reduces rotation_steps modulo the ring perimeter (one bit of the 32-bit count
// per cycle), MAP from the shifted ring position to a row and column, and the
// store's registered read; a centre line or cell goes from SIZE to the read.
// The result is presented on read_value with done high for exactly one cycle,
// in the cycle where busy has already dropped; the receiver cannot stall it, so
// it must capture read_value whenever done is high. A read of a position
// outside the configured size returns zero straight from GEOM. Entries must be
// written before they are read: the store has no reset and no clearing pass.
// Configuration registers sit on the APB port at byte addresses 0 (row_count),
// 4 (col_count) and 8 (rotation_steps); dimensions are clamped to 2..MAX_DIM
// when written, and should only be changed while busy is low.
module matrix_ring_rotator_top
	import mrr_pkg::*;
#(
	parameter int MAX_DIM = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// Request channel
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              operation,
	input  wire logic [IDX_W-1:0]  row_index,
	input  wire logic [IDX_W-1:0]  col_index,
	input  wire logic [DATA_W-1:0] write_value,
	// Result channel
	output logic                   done,
	output logic      [DATA_W-1:0] read_value,
	// Configuration port
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [3:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);

	// One-hot sequencer for a read request.
	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_GEOM  = 8'b0000_0010,
		S_SIZE  = 8'b0000_0100,
		S_POS   = 8'b0000_1000,
		S_DIV   = 8'b0001_0000,
		S_MAP   = 8'b0010_0000,
		S_FETCH = 8'b0100_0000,
		S_DATA  = 8'b1000_0000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [DIM_W-1:0]  row_cnt_q;
	logic [DIM_W-1:0]  col_cnt_q;
	logic [DATA_W-1:0] rot_q;
	logic              cfg_wr;

	// Request and ring registers.
	logic [IDX_W-1:0]  r_q;
	logic [IDX_W-1:0]  c_q;
	logic [DIM_W-1:0]  d_q;
	logic [PER_W-1:0]  h_q;
	logic [PER_W-1:0]  w_q;
	logic [PER_W-1:0]  i_q;
	logic [PER_W-1:0]  j_q;
	logic [PER_W-1:0]  per_q;
	logic [PER_W-1:0]  p_q;
	logic [PER_W-1:0]  q_q;
	logic [DIM_W-1:0]  frow_q;
	logic [DIM_W-1:0]  fcol_q;
	logic              done_q;
	logic [DATA_W-1:0] read_value_q;

	// Datapath nets.
	logic              accept;
	logic              wr_accept;
	logic              wr_in_store;
	logic [DIM_W-1:0]  rx;
	logic [DIM_W-1:0]  cx;
	logic              outside;
	logic [DIM_W-1:0]  near_lo;
	logic [DIM_W-1:0]  near_hi;
	logic [DIM_W-1:0]  depth_d;
	logic [DIM_W-1:0]  h_d;
	logic [DIM_W-1:0]  w_d;
	logic              centre;
	logic [PER_W-1:0]  per_d;
	logic [PER_W-1:0]  p_d;
	logic [PER_W:0]    sum_d;
	logic [PER_W-1:0]  q_d;
	logic [PER_W-1:0]  fi_d;
	logic [PER_W-1:0]  fj_d;
	logic [PER_W-1:0]  lim1;
	logic [PER_W-1:0]  lim2;
	logic [PER_W-1:0]  lim3;
	logic [AW-1:0]     waddr;
	logic [AW-1:0]     raddr;
	logic              ram_re;
	logic [DATA_W-1:0] ram_rdata;
	rem_req_t          rem_req;
	rem_rsp_t          rem_rsp;

	// Dimensions saturate into 2..MAX_DIM when written.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] res;
		res = v;
		if (v < DIM_MIN) begin
			res = DIM_MIN;
		end else if (32'(v) > 32'(MAX_DIM)) begin
			res = DIM_W'(MAX_DIM);
		end
		return res;
	endfunction

	// ---------------------------------------------------------------
	// Configuration port: zero-wait APB, registers decoded on word index.
	// ---------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cnt_q <= DIM_RESET;
			col_cnt_q <= DIM_RESET;
			rot_q     <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_ROW_COUNT:      row_cnt_q <= clamp_dim(pwdata[DIM_W-1:0]);
				REG_COL_COUNT:      col_cnt_q <= clamp_dim(pwdata[DIM_W-1:0]);
				REG_ROTATION_STEPS: rot_q     <= pwdata;
				default:            ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_ROW_COUNT:      prdata = 32'(row_cnt_q);
			REG_COL_COUNT:      prdata = 32'(col_cnt_q);
			REG_ROTATION_STEPS: prdata = rot_q;
			default:            prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// Request acceptance. Writes go straight into the store; a write
	// whose row or column falls beyond the store is dropped.
	// ---------------------------------------------------------------
	assign busy        = (state_q != S_IDLE);
	assign accept      = start && !busy;
	assign wr_in_store = (32'(row_index) < 32'(MAX_DIM)) && (32'(col_index) < 32'(MAX_DIM));
	assign wr_accept   = accept && (operation == OP_WRITE) && wr_in_store;
	assign waddr       = AW'(AW'(row_index) * AW'(MAX_DIM)) + AW'(col_index);

	// ---------------------------------------------------------------
	// Ring geometry. The ring depth is the distance to the nearest edge;
	// the ring is then h_d by w_d, and the position is walked clockwise
	// from its top-left corner: top row, right column, bottom row, left.
	// ---------------------------------------------------------------
	always_comb begin
		rx      = DIM_W'(r_q);
		cx      = DIM_W'(c_q);
		outside = (rx >= row_cnt_q) || (cx >= col_cnt_q);
		near_lo = (rx < cx) ? rx : cx;
		if ((row_cnt_q - DIM_W'(1) - rx) < (col_cnt_q - DIM_W'(1) - cx)) begin
			near_hi = row_cnt_q - DIM_W'(1) - rx;
		end else begin
			near_hi = col_cnt_q - DIM_W'(1) - cx;
		end
		depth_d = (near_lo < near_hi) ? near_lo : near_hi;
	end

	always_comb begin
		h_d    = row_cnt_q - (d_q << 1);
		w_d    = col_cnt_q - (d_q << 1);
		centre = (h_d < DIM_W'(2)) || (w_d < DIM_W'(2));
		per_d  = PER_W'((PER_W'(h_d) + PER_W'(w_d)) << 1) - PER_W'(4);
	end

	always_comb begin
		if ((i_q == '0) && (j_q < w_q - PER_W'(1))) begin
			p_d = j_q;
		end else if ((j_q == w_q - PER_W'(1)) && (i_q < h_q - PER_W'(1))) begin
			p_d = w_q - PER_W'(1) + i_q;
		end else if ((i_q == h_q - PER_W'(1)) && (j_q != '0)) begin
			p_d = (w_q + h_q - PER_W'(2)) + (w_q - PER_W'(1) - j_q);
		end else begin
			p_d = ((w_q << 1) + h_q - PER_W'(3)) + (h_q - PER_W'(1) - i_q);
		end
	end

	// Both p_q and the remainder are below the perimeter, so one
	// conditional subtract finishes the modulo.
	always_comb begin
		sum_d = {1'b0, p_q} + {1'b0, rem_rsp.remainder};
		if (sum_d >= {1'b0, per_q}) begin
			q_d = PER_W'(sum_d - {1'b0, per_q});
		end else begin
			q_d = sum_d[PER_W-1:0];
		end
	end

	// Shifted ring position back to ring-local row and column.
	always_comb begin
		lim1 = w_q - PER_W'(1);
		lim2 = w_q + h_q - PER_W'(2);
		lim3 = (w_q << 1) + h_q - PER_W'(3);
		if (q_q < lim1) begin
			fi_d = '0;
			fj_d = q_q;
		end else if (q_q < lim2) begin
			fi_d = q_q - lim1;
			fj_d = lim1;
		end else if (q_q < lim3) begin
			fi_d = h_q - PER_W'(1);
			fj_d = lim1 - (q_q - lim2);
		end else begin
			fi_d = h_q - PER_W'(1) - (q_q - lim3);
			fj_d = '0;
		end
	end

	// ---------------------------------------------------------------
	// Sequencer.
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && (operation == OP_READ)) begin
						state_q <= S_GEOM;
					end
				end
				S_GEOM: begin
					if (outside) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_SIZE;
					end
				end
				S_SIZE: begin
					state_q <= centre ? S_FETCH : S_POS;
				end
				S_POS: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (rem_rsp.done) begin
						state_q <= S_MAP;
					end
				end
				S_MAP: begin
					state_q <= S_FETCH;
				end
				S_FETCH: begin
					state_q <= S_DATA;
				end
				S_DATA: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					r_q <= row_index;
					c_q <= col_index;
				end
			end
			S_GEOM: begin
				d_q          <= depth_d;
				read_value_q <= '0;
			end
			S_SIZE: begin
				h_q    <= PER_W'(h_d);
				w_q    <= PER_W'(w_d);
				i_q    <= PER_W'(DIM_W'(r_q) - d_q);
				j_q    <= PER_W'(DIM_W'(c_q) - d_q);
				per_q  <= per_d;
				frow_q <= DIM_W'(r_q);
				fcol_q <= DIM_W'(c_q);
			end
			S_POS: begin
				p_q <= p_d;
			end
			S_DIV: begin
				q_q <= q_d;
			end
			S_MAP: begin
				frow_q <= DIM_W'(fi_d + PER_W'(d_q));
				fcol_q <= DIM_W'(fj_d + PER_W'(d_q));
			end
			S_FETCH: begin
			end
			S_DATA: begin
				read_value_q <= ram_rdata;
			end
			default: begin
			end
		endcase
	end

	assign done       = done_q;
	assign read_value = read_value_q;

	// ---------------------------------------------------------------
	// Remainder unit: rotation_steps modulo the ring perimeter.
	// ---------------------------------------------------------------
	assign rem_req.start    = (state_q == S_POS);
	assign rem_req.dividend = rot_q;
	assign rem_req.divisor  = per_q;

	mrr_rem_unit u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.rsp    (rem_rsp)
	);

	// ---------------------------------------------------------------
	// Matrix store.
	// ---------------------------------------------------------------
	assign ram_re = (state_q == S_FETCH);
	assign raddr  = AW'(AW'(frow_q) * AW'(MAX_DIM)) + AW'(fcol_q);

	mrr_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (wr_accept),
		.waddr (waddr),
		.wdata (write_value),
		.re    (ram_re),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	// ---------------------------------------------------------------
	// Checks.
	// ---------------------------------------------------------------
	`MRR_NEVER(a_done_while_busy, clk, arst_n, done && busy)
	`MRR_ASSERT(a_read_goes_busy, clk, arst_n, (accept && (operation == OP_READ)) |=> busy)
	`MRR_ASSERT(a_write_no_result, clk, arst_n, (accept && (operation == OP_WRITE)) |=> (!busy && !done))
	`MRR_ASSERT(a_rem_done_in_div, clk, arst_n, rem_rsp.done |-> (state_q == S_DIV))

endmodule
`default_nettype wire

// ----- tb/matrix_ring_rotator_top_test.sv -----
// Self-checking testbench for matrix_ring_rotator_top: directed table, then random requests.
`timescale 1ns / 1ps

// The testbench keeps its own shadow of the matrix store and of the three
// configuration registers. When a read request is accepted, the ring
// rotation predictor works out the source entry. The expected element goes
// into a queue that the result checker drains whenever done is high.
// Reads only ever reach entries that were written before. If a read would
// land on a fresh entry, a write of a random value to that entry is sent
// first.
module matrix_ring_rotator_top_test;
	import mrr_pkg::*;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 45;
	localparam int PHASE_COUNT   = 14;
	localparam int PHASE_ITEMS   = 60;

	typedef enum logic {STEP_REQUEST, STEP_CONFIG} step_kind_t;

	// One row of the directed table. A config row uses reg_sel and data.
	// A request row uses op, row, col and data. Where checked is set, the
	// expected element is the literal and not the predictor's value.
	typedef struct packed {
		step_kind_t  kind;
		logic        op;
		logic [7:0]  row;
		logic [7:0]  col;
		logic [31:0] data;
		logic [1:0]  reg_sel;
		logic        checked;
		logic [31:0] literal;
	} directed_step_t;

	typedef struct packed {
		logic       in_matrix;
		logic [7:0] row;
		logic [7:0] col;
	} source_pos_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        operation;
	logic [7:0]  row_index;
	logic [7:0]  col_index;
	logic [31:0] write_value;
	logic        done;
	logic [31:0] read_value;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// Shadow state of the block.
	logic [31:0]  matrix_shadow [65536];
	bit           entry_written [65536];
	int unsigned  cfg_rows;
	int unsigned  cfg_cols;
	logic [31:0]  cfg_steps;
	logic [31:0]  pending_reads [$];

	int unsigned  sender_idle_pct;
	int unsigned  error_count;
	int unsigned  cycle_count;

	// The directed part starts at the reset size of 2x2 with no rotation.
	// The literal rows can be read straight off the four entries written first.
	directed_step_t directed_steps [25] = '{
		'{STEP_REQUEST, OP_WRITE, 8'd0,   8'd0,   32'h7FFF_FFFF, REG_ROW_COUNT, 1'b0, 32'h0},
		'{STEP_REQUEST, OP_WRITE, 8'd0,   8'd1,   32'h8000_0000, REG_ROW_COUNT, 1'b0, 32'h0},
		'{STEP_REQUEST, OP_WRITE, 8'd1,   8'd0,   32'hFFFF_FFFF, REG_ROW_COUNT, 1'b0, 32'h0},
		'{STEP_REQUEST, OP_WRITE, 8'd1,   8'd1,   32'h0000_0000, REG_ROW_COUNT, 1'b0, 32'h0},
		'{STEP_REQUEST, OP_READ,  8'd0,   8'd0,   32'h0, REG_ROW_COUNT, 1'b1, 32'h7FFF_FFFF},
		'{STEP_REQUEST, OP_READ,  8'd1,   8'd0,   32'h0, REG_ROW_COUNT, 1'b1, 32'hFFFF_FFFF},
		// Reads outside the configured size give zero.
		'{STEP_REQUEST, OP_READ,  8'd2,   8'd0,   32'h0, REG_ROW_COUNT, 1'b1, 32'h0},
		'{STEP_REQUEST, OP_READ,  8'd0,   8'd255, 32'h0, REG_ROW_COUNT, 1'b1, 32'h0},
		'{STEP_REQUEST, OP_READ,  8'd255, 8'd255, 32'h0, REG_ROW_COUNT, 1'b1, 32'h0},
		// Writes outside the configured size but inside the store are kept.
		'{STEP_REQUEST, OP_WRITE, 8'd255, 8'd255, 32'h1234_5678, REG_ROW_COUNT, 1'b0, 32'h0},
		'{STEP_REQUEST, OP_WRITE, 8'd255, 8'd0,   32'hA5A5_A5A5, REG_ROW_COUNT, 1'b0, 32'h0},
		'{STEP_CONFIG,  OP_WRITE, 8'd0,   8'd0,   32'h1, REG_ROTATION_STEPS, 1'b0, 32'h0},
		'{STEP_REQUEST, OP_READ,  8'd0,   8'd0,   32'h0, REG_ROW_COUNT, 1'b0, 32'h0},
		'{STEP_CONFIG,  OP_WRITE, 8'd0,   8'd0,   32'hFFFF_FFFF, REG_ROTATION_STEPS, 1'b0, 32'h0},
		'{STEP_REQUEST, OP_READ,  8'd1,   8'd1,   32'h0, REG_ROW_COUNT, 1'b0, 32'h0},
		// A row count below the minimum is clamped up to 2.
		'{STEP_CONFIG,  OP_WRITE, 8'd0,   8'd0,   32'h0, REG_ROW_COUNT, 1'b0, 32'h0},
		'{STEP_REQUEST, OP_READ,  8'd1,   8'd0,   32'h0, REG_ROW_COUNT, 1'b0, 32'h0},
		// Counts above the store size saturate, and only nine bits are kept.
		'{STEP_CONFIG,  OP_WRITE, 8'd0,   8'd0,   32'h0000_01FF, REG_ROW_COUNT, 1'b0, 32'h0},
		'{STEP_CONFIG,  OP_WRITE, 8'd0,   8'd0,   32'hFFFF_FE03, REG_COL_COUNT, 1'b0, 32'h0},
		'{STEP_REQUEST, OP_READ,  8'd255, 8'd2,   32'h0, REG_ROW_COUNT, 1'b0, 32'h0},
		// At 256x3 the middle column is a centre line that does not rotate.
		'{STEP_REQUEST, OP_READ,  8'd100, 8'd1,   32'h0, REG_ROW_COUNT, 1'b0, 32'h0},
		'{STEP_CONFIG,  OP_WRITE, 8'd0,   8'd0,   32'h5, REG_ROW_COUNT, 1'b0, 32'h0},
		'{STEP_CONFIG,  OP_WRITE, 8'd0,   8'd0,   32'h5, REG_COL_COUNT, 1'b0, 32'h0},
		'{STEP_CONFIG,  OP_WRITE, 8'd0,   8'd0,   32'h2, REG_ROTATION_STEPS, 1'b0, 32'h0},
		// At 5x5 the centre cell is left unrotated.
		'{STEP_REQUEST, OP_READ,  8'd2,   8'd2,   32'h0, REG_ROW_COUNT, 1'b0, 32'h0}
	};

	matrix_ring_rotator_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.operation   (operation),
		.row_index   (row_index),
		.col_index   (col_index),
		.write_value (write_value),
		.done        (done),
		.read_value  (read_value),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned smaller(int unsigned a, int unsigned b);
		return (a < b) ? a : b;
	endfunction

	function automatic int unsigned clamp_dim(logic [31:0] raw);
		int unsigned v;
		v = raw[8:0];
		if (v < 2)
			return 2;
		if (v > 256)
			return 256;
		return v;
	endfunction

	// Finds the stored entry that a read of (r, c) returns under the current
	// size and rotation. The entry is the one that lands on (r, c) once its
	// ring moves counterclockwise. in_matrix is clear for a position outside
	// the configured matrix.
	function automatic source_pos_t ring_source(int unsigned r, int unsigned c);
		source_pos_t src;
		int unsigned d, h, w, i, j, p, q, per;
		src.in_matrix = 1'b0;
		src.row = r[7:0];
		src.col = c[7:0];
		if (r >= cfg_rows || c >= cfg_cols)
			return src;
		src.in_matrix = 1'b1;
		d = smaller(smaller(r, c), smaller(cfg_rows - 1 - r, cfg_cols - 1 - c));
		h = cfg_rows - 2 * d;
		w = cfg_cols - 2 * d;
		// A centre line or centre cell stays where it is.
		if (h < 2 || w < 2)
			return src;
		i = r - d;
		j = c - d;
		per = 2 * (h + w) - 4;
		// Position along the ring, clockwise from the top left corner.
		if (i == 0 && j < w - 1)
			p = j;
		else if (j == w - 1 && i < h - 1)
			p = (w - 1) + i;
		else if (i == h - 1 && j > 0)
			p = (w + h - 2) + (w - 1 - j);
		else
			p = (2 * w + h - 3) + (h - 1 - i);
		q = (p + cfg_steps % per) % per;
		if (q < w - 1) begin
			i = 0;
			j = q;
		end else if (q < w + h - 2) begin
			i = q - (w - 1);
			j = w - 1;
		end else if (q < 2 * w + h - 3) begin
			i = h - 1;
			j = w - 1 - (q - (w + h - 2));
		end else begin
			i = h - 1 - (q - (2 * w + h - 3));
			j = 0;
		end
		src.row = 8'(i + d);
		src.col = 8'(j + d);
		return src;
	endfunction

	function automatic logic [31:0] rotated_element(int unsigned r, int unsigned c);
		source_pos_t src;
		src = ring_source(r, c);
		return src.in_matrix ? matrix_shadow[{src.row, src.col}] : 32'h0;
	endfunction

	function automatic logic [31:0] random_element();
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0;
			default: return $urandom;
		endcase
	endfunction

	// Presents one request and returns right after the edge that accepts it.
	// Every call starts just after a rising edge, so start gets one update per
	// time step. busy is sampled at the falling edge, where it is stable.
	task automatic send_request(input logic op, input logic [7:0] r, input logic [7:0] c,
			input logic [31:0] v);
		bit taken;
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start       <= 1'b1;
		operation   <= op;
		row_index   <= r;
		col_index   <= c;
		write_value <= v;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic store_element(input logic [7:0] r, input logic [7:0] c,
			input logic [31:0] v);
		send_request(OP_WRITE, r, c, v);
		matrix_shadow[{r, c}] = v;
		entry_written[{r, c}] = 1'b1;
	endtask

	// A read whose source entry was never written would return garbage.
	// That entry gets a random value first, so the read stays inside the
	// contract and still shows which entry the block fetched.
	task automatic fetch_element(input logic [7:0] r, input logic [7:0] c,
			input bit use_literal, input logic [31:0] literal);
		source_pos_t src;
		src = ring_source(r, c);
		if (src.in_matrix && !entry_written[{src.row, src.col}])
			store_element(src.row, src.col, random_element());
		send_request(OP_READ, r, c, 32'h0);
		pending_reads.push_back(use_literal ? literal : rotated_element(r, c));
	endtask

	// Registers change only while the block is idle. All reads must have
	// come back, and then the block gets a read's full latency to settle.
	// The APB write has a setup phase and then an access phase. The access
	// phase is held until pready is seen.
	task automatic write_register(input logic [1:0] reg_sel, input logic [31:0] value);
		bit ready;
		start <= 1'b0;
		while (pending_reads.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_sel, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			ready = pready;
			@(posedge clk);
		end while (!ready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (reg_sel)
			REG_ROW_COUNT:      cfg_rows = clamp_dim(value);
			REG_COL_COUNT:      cfg_cols = clamp_dim(value);
			REG_ROTATION_STEPS: cfg_steps = value;
			default: ;
		endcase
	endtask

	// Most phases use small matrices so that reads come back to entries
	// written earlier. Raw values below 2 and above 256 exercise the clamp.
	function automatic logic [31:0] random_dim();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 40)
			return $urandom_range(8, 2);
		if (roll < 60)
			return $urandom_range(32, 9);
		if (roll < 75)
			return 32'd2;
		if (roll < 90)
			return 32'd256;
		return $urandom_range(511);
	endfunction

	function automatic logic [31:0] random_steps();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 25)
			return $urandom_range(2 * (cfg_rows + cfg_cols));
		if (roll < 40)
			return 32'h0;
		if (roll < 55)
			return 32'hFFFF_FFFF;
		return $urandom;
	endfunction

	// One random request. Reads inside the matrix, which exercise the rotation,
	// and writes inside the matrix make up most of the draws. Out-of-range reads
	// and writes anywhere in the store make up the rest.
	task automatic random_request();
		int unsigned roll;
		logic [7:0] r, c;
		roll = $urandom_range(99);
		r = 8'($urandom_range(cfg_rows - 1));
		c = 8'($urandom_range(cfg_cols - 1));
		if (roll < 45) begin
			fetch_element(r, c, 1'b0, 32'h0);
		end else if (roll < 55) begin
			if (cfg_rows < 256 && (cfg_cols == 256 || $urandom_range(1) == 0))
				r = 8'($urandom_range(255, cfg_rows));
			else if (cfg_cols < 256)
				c = 8'($urandom_range(255, cfg_cols));
			fetch_element(r, c, 1'b0, 32'h0);
		end else if (roll < 90) begin
			store_element(r, c, random_element());
		end else begin
			store_element(8'($urandom_range(255)), 8'($urandom_range(255)),
				random_element());
		end
	endtask

	// Results cannot be held off, so each one is taken in the cycle where
	// done is high. It is sampled at the falling edge, away from the edge
	// that updates it.
	always @(negedge clk) begin
		logic [31:0] want;
		if (arst_n && done) begin
			if (pending_reads.size() == 0) begin
				$error("read_value: no read outstanding, actual %h", read_value);
				error_count++;
			end else begin
				want = pending_reads.pop_front();
				if (read_value !== want) begin
					$error("read_value: expected %h, actual %h", want, read_value);
					error_count++;
				end
			end
		end
	end

	// The timeout covers the slowest correct run several times over.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		arst_n          = 1'b0;
		start           = 1'b0;
		operation       = OP_WRITE;
		row_index       = '0;
		col_index       = '0;
		write_value     = '0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		cfg_rows        = DIM_RESET;
		cfg_cols        = DIM_RESET;
		cfg_steps       = '0;
		sender_idle_pct = 26;
		error_count     = 0;
		cycle_count     = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table.
		foreach (directed_steps[k]) begin
			if (directed_steps[k].kind == STEP_CONFIG)
				write_register(directed_steps[k].reg_sel, directed_steps[k].data);
			else if (directed_steps[k].op == OP_WRITE)
				store_element(directed_steps[k].row, directed_steps[k].col,
					directed_steps[k].data);
			else
				fetch_element(directed_steps[k].row, directed_steps[k].col,
					directed_steps[k].checked, directed_steps[k].literal);
		end

		// Random phases. Each phase writes every register and then sends a
		// batch of requests. The sender first idles lightly, then heavily,
		// and the last phases run back to back. The first phases pin the
		// extreme sizes and rotation counts.
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			sender_idle_pct = (phase < 5) ? 26 : (phase < 10) ? 54 : 0;
			case (phase)
				0: begin
					write_register(REG_ROW_COUNT, 32'd256);
					write_register(REG_COL_COUNT, 32'd256);
					write_register(REG_ROTATION_STEPS, 32'hFFFF_FFFF);
				end
				1: begin
					write_register(REG_ROW_COUNT, 32'd2);
					write_register(REG_COL_COUNT, 32'd256);
					write_register(REG_ROTATION_STEPS, 32'h0);
				end
				2: begin
					write_register(REG_ROW_COUNT, 32'd256);
					write_register(REG_COL_COUNT, 32'd2);
					write_register(REG_ROTATION_STEPS, $urandom);
				end
				default: begin
					write_register(REG_ROW_COUNT, random_dim());
					write_register(REG_COL_COUNT, random_dim());
					write_register(REG_ROTATION_STEPS, random_steps());
				end
			endcase
			repeat (PHASE_ITEMS) random_request();
		end

		// Drain: every read must come back, and nothing may follow after that.
		start <= 1'b0;
		while (pending_reads.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/mrr_pkg.sv
rtl/core/mrr_ram.sv
rtl/core/mrr_rem_unit.sv
rtl/core/matrix_ring_rotator_top.sv
tb/matrix_ring_rotator_top_test.sv
